>>> src/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the line stepper: command and register
// codes, image size defaults, and the control structs passed between units.
// ----------------------------------------------------------------------------
package bls_pkg;

   // image dimension registers are fixed at 12 bits
   localparam int DIM_BITS       = 12;
   localparam int CSR_INDEX_BITS = 1;
   localparam int COLOR_BITS     = 32;

   // command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // register reset values
   localparam logic [DIM_BITS-1:0] IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [DIM_BITS-1:0] IMAGE_HEIGHT_RESET = 12'd480;

   // direction and major-axis flags of a line
   typedef struct packed {
      logic x_backward;
      logic y_backward;
      logic x_major;
   } line_dir_type;

   // what the stepper does this cycle
   typedef struct packed {
      logic start;
      logic step;
   } step_ctrl_type;

endpackage

>>> src/bls_if.sv
// ----------------------------------------------------------------------------
// bls_if
// Valid/ready channels of the line stepper: command channel and pixel
// channel.
// ----------------------------------------------------------------------------
interface bls_req_if #(
   parameter int COORD_BITS = 12
);
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic [31:0]                  color;

   modport source (output valid, cmd, start_x, start_y, end_x, end_y, color,
                   input ready);
   modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, color,
                   output ready);
endinterface

interface bls_rsp_if #(
   parameter int COORD_BITS = 12
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic [31:0]                  pixel_color;
   logic                         visible;
   logic                         last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, visible, last,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, visible, last,
                   output ready);
endinterface

>>> src/bls_setup.sv
// ----------------------------------------------------------------------------
// bls_setup
// Line setup: absolute deltas, step directions, major axis (tie goes to y)
// and the seed of the decision variable.
// ----------------------------------------------------------------------------
module bls_setup #(
   parameter int COORD_BITS = 12
) (
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output bls_pkg::line_dir_type        dir,
   output logic [COORD_BITS-1:0]        delta_major,
   output logic [COORD_BITS-1:0]        delta_minor,
   output logic signed [COORD_BITS+2:0] error_seed
);
   import bls_pkg::*;

   localparam int DW       = COORD_BITS + 1;
   localparam int ERR_BITS = COORD_BITS + 3;

   logic signed [DW-1:0]  diff_x;
   logic signed [DW-1:0]  diff_y;
   logic [DW-1:0]         abs_x_full;
   logic [DW-1:0]         abs_y_full;
   logic [COORD_BITS-1:0] abs_x;
   logic [COORD_BITS-1:0] abs_y;

   // signed differences, one bit wider than the coordinates
   assign diff_x = DW'(end_x) - DW'(start_x);
   assign diff_y = DW'(end_y) - DW'(start_y);

   // magnitudes always fit the coordinate width
   assign abs_x_full = diff_x[DW-1] ? -diff_x : diff_x;
   assign abs_y_full = diff_y[DW-1] ? -diff_y : diff_y;
   assign abs_x      = abs_x_full[COORD_BITS-1:0];
   assign abs_y      = abs_y_full[COORD_BITS-1:0];

   // directions and major axis
   always_comb begin
      dir.x_backward = diff_x[DW-1];
      dir.y_backward = diff_y[DW-1];
      dir.x_major    = abs_x > abs_y;
   end

   assign delta_major = dir.x_major ? abs_x : abs_y;
   assign delta_minor = dir.x_major ? abs_y : abs_x;

   // e0 = 2*dminor - dmajor
   assign error_seed = ERR_BITS'({delta_minor, 1'b0}) - ERR_BITS'(delta_major);

endmodule

>>> src/bls_stepper.sv
// ----------------------------------------------------------------------------
// bls_stepper
// Line state registers and the per-pixel step: major axis always moves,
// minor axis moves when the decision variable is non-negative.
// ----------------------------------------------------------------------------
module bls_stepper #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bls_pkg::step_ctrl_type       ctrl,
   input  bls_pkg::line_dir_type        setup_dir,
   input  logic [COORD_BITS-1:0]        setup_major,
   input  logic [COORD_BITS-1:0]        setup_minor,
   input  logic signed [COORD_BITS+2:0] setup_error,
   input  logic signed [COORD_BITS-1:0] setup_x,
   input  logic signed [COORD_BITS-1:0] setup_y,
   input  logic [31:0]                  setup_color,
   output logic signed [COORD_BITS-1:0] pix_x,
   output logic signed [COORD_BITS-1:0] pix_y,
   output logic [31:0]                  pix_color,
   output logic                         pix_last,
   output logic                         busy
);
   import bls_pkg::*;

   localparam int ERR_BITS = COORD_BITS + 3;

   // line state
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]        major_ff, major_in;
   logic [COORD_BITS-1:0]        minor_ff, minor_in;
   line_dir_type                 dir_ff, dir_in;
   logic signed [ERR_BITS-1:0]   error_ff, error_in;
   logic [COORD_BITS-1:0]        steps_ff, steps_in;
   logic [COLOR_BITS-1:0]        color_ff, color_in;
   logic                         busy_ff, busy_in;

   logic                         move_minor;
   logic signed [ERR_BITS-1:0]   error_inc;
   logic signed [COORD_BITS-1:0] step_x;
   logic signed [COORD_BITS-1:0] step_y;

   // one step from the current state
   assign move_minor = !error_ff[ERR_BITS-1];
   assign error_inc  = move_minor
                     ? ERR_BITS'({minor_ff, 1'b0}) - ERR_BITS'({major_ff, 1'b0})
                     : ERR_BITS'({minor_ff, 1'b0});
   assign step_x = dir_ff.x_backward ? cur_x_ff - COORD_BITS'(1) : cur_x_ff + COORD_BITS'(1);
   assign step_y = dir_ff.y_backward ? cur_y_ff - COORD_BITS'(1) : cur_y_ff + COORD_BITS'(1);

   // next state: start loads a new line, step advances the current one
   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      dir_in   = dir_ff;
      error_in = error_ff;
      steps_in = steps_ff;
      color_in = color_ff;
      busy_in  = busy_ff;
      if (ctrl.start) begin
         cur_x_in = setup_x;
         cur_y_in = setup_y;
         major_in = setup_major;
         minor_in = setup_minor;
         dir_in   = setup_dir;
         error_in = setup_error;
         steps_in = setup_major;
         color_in = setup_color;
         busy_in  = setup_major != '0;
      end else if (ctrl.step && busy_ff) begin
         error_in = error_ff + error_inc;
         if (dir_ff.x_major || move_minor) begin
            cur_x_in = step_x;
         end
         if (!dir_ff.x_major || move_minor) begin
            cur_y_in = step_y;
         end
         steps_in = steps_ff - COORD_BITS'(1);
         busy_in  = steps_in != '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // line payload
   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      major_ff <= major_in;
      minor_ff <= minor_in;
      dir_ff   <= dir_in;
      error_ff <= error_in;
      steps_ff <= steps_in;
      color_ff <= color_in;
   end

   // the emitted pixel is the new current pixel
   assign pix_x     = cur_x_in;
   assign pix_y     = cur_y_in;
   assign pix_color = color_in;
   assign pix_last  = !busy_in;
   assign busy      = busy_ff;

endmodule

>>> src/bresenham_line_stepper_unit.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper_unit
// Bresenham line rasterizer: a start transaction sets up a line and emits
// its first pixel, each step transaction emits the next pixel.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    cmd, start_x, start_y, end_x, end_y, color
//   rsp_ch   out  valid/ready    pixel_x, pixel_y, pixel_color, visible, last
//   csr_*    in   csr_we         csr_index, csr_wdata (image width/height)
//
// One transaction per cycle while rsp_ch does not stall: a command is held in
// the input register, then setup or step logic updates the line state and
// loads the pixel into the output register.
// Reset (synchronous) empties both registers and leaves the stepper idle.
// A stalled rsp_ch holds the output register; the input register then fills
// and req_ch.ready drops. A step while idle passes without using rsp_ch.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_unit #(
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bls_req_if.sink                              req_ch,
   bls_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic [bls_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bls_pkg::DIM_BITS-1:0]         csr_wdata
);
   import bls_pkg::*;

   localparam int CMP_BITS = (COORD_BITS > DIM_BITS ? COORD_BITS : DIM_BITS) + 1;

   // image size registers
   logic [DIM_BITS-1:0] width_ff;
   logic [DIM_BITS-1:0] height_ff;

   // input register
   logic                         in_valid_ff, in_valid_in;
   logic                         in_cmd_ff;
   logic signed [COORD_BITS-1:0] in_sx_ff;
   logic signed [COORD_BITS-1:0] in_sy_ff;
   logic signed [COORD_BITS-1:0] in_ex_ff;
   logic signed [COORD_BITS-1:0] in_ey_ff;
   logic [COLOR_BITS-1:0]        in_color_ff;

   // output register
   logic                         out_valid_ff, out_valid_in;
   logic signed [COORD_BITS-1:0] out_x_ff;
   logic signed [COORD_BITS-1:0] out_y_ff;
   logic [COLOR_BITS-1:0]        out_color_ff;
   logic                         out_visible_ff;
   logic                         out_last_ff;

   // setup and stepper wiring
   line_dir_type                 setup_dir;
   logic [COORD_BITS-1:0]        setup_major;
   logic [COORD_BITS-1:0]        setup_minor;
   logic signed [COORD_BITS+2:0] setup_error;
   step_ctrl_type                ctrl;
   logic signed [COORD_BITS-1:0] pix_x;
   logic signed [COORD_BITS-1:0] pix_y;
   logic [COLOR_BITS-1:0]        pix_color;
   logic                         pix_last;
   logic                         busy;

   logic req_fire;
   logic produce;
   logic advance;
   logic load_out;
   logic x_in_range;
   logic y_in_range;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // flow control
   assign produce      = (in_cmd_ff == CMD_START) || busy;
   assign advance      = in_valid_ff && (!produce || !out_valid_ff || rsp_ch.ready);
   assign load_out     = advance && produce;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = load_out || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff   <= req_ch.cmd;
         in_sx_ff    <= req_ch.start_x;
         in_sy_ff    <= req_ch.start_y;
         in_ex_ff    <= req_ch.end_x;
         in_ey_ff    <= req_ch.end_y;
         in_color_ff <= req_ch.color;
      end
   end

   // line setup
   bls_setup #(
      .COORD_BITS (COORD_BITS)
   ) u_setup (
      .start_x     (in_sx_ff),
      .start_y     (in_sy_ff),
      .end_x       (in_ex_ff),
      .end_y       (in_ey_ff),
      .dir         (setup_dir),
      .delta_major (setup_major),
      .delta_minor (setup_minor),
      .error_seed  (setup_error)
   );

   // stepper
   always_comb begin
      ctrl.start = advance && (in_cmd_ff == CMD_START);
      ctrl.step  = advance && (in_cmd_ff == CMD_STEP);
   end

   bls_stepper #(
      .COORD_BITS (COORD_BITS)
   ) u_stepper (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .setup_dir   (setup_dir),
      .setup_major (setup_major),
      .setup_minor (setup_minor),
      .setup_error (setup_error),
      .setup_x     (in_sx_ff),
      .setup_y     (in_sy_ff),
      .setup_color (in_color_ff),
      .pix_x       (pix_x),
      .pix_y       (pix_y),
      .pix_color   (pix_color),
      .pix_last    (pix_last),
      .busy        (busy)
   );

   // visibility against the image bounds
   assign x_in_range = !pix_x[COORD_BITS-1] &&
                       (CMP_BITS'($unsigned(pix_x)) < CMP_BITS'(width_ff));
   assign y_in_range = !pix_y[COORD_BITS-1] &&
                       (CMP_BITS'($unsigned(pix_y)) < CMP_BITS'(height_ff));

   // output register payload
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_x_ff       <= pix_x;
         out_y_ff       <= pix_y;
         out_color_ff   <= pix_color;
         out_visible_ff <= x_in_range && y_in_range;
         out_last_ff    <= pix_last;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.pixel_x     = out_x_ff;
   assign rsp_ch.pixel_y     = out_y_ff;
   assign rsp_ch.pixel_color = out_color_ff;
   assign rsp_ch.visible     = out_visible_ff;
   assign rsp_ch.last        = out_last_ff;

endmodule

>>> src/bls_checker.sv
// ----------------------------------------------------------------------------
// bls_checker
// Port-level checks for the line stepper, bound to the top level.
// ----------------------------------------------------------------------------
module bls_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_cmd,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS-1:0] rsp_pixel_x,
   input logic signed [COORD_BITS-1:0] rsp_pixel_y,
   input logic [31:0]                  rsp_pixel_color
);
   import bls_pkg::*;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // a stalled pixel holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x) &&
      $stable(rsp_pixel_y) && $stable(rsp_pixel_color))
      else $error("pixel changed or dropped while stalled");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel valid right after reset");

   // a start followed by rsp_ready is answered with a pixel
   a_start_answer: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_cmd == CMD_START) ##1 rsp_ready |=> rsp_valid)
      else $error("start transaction produced no pixel");

   // a pixel only appears after an accepted transaction
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_fire, 2))
      else $error("pixel without a preceding transaction");

endmodule

bind bresenham_line_stepper_unit bls_checker #(
   .COORD_BITS (COORD_BITS)
) u_bls_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_cmd         (req_ch.cmd),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_pixel_x     (rsp_ch.pixel_x),
   .rsp_pixel_y     (rsp_ch.pixel_y),
   .rsp_pixel_color (rsp_ch.pixel_color)
);
